/* src/tli_pkg.sv */
// shared constants, codes and types for the table linear interpolator
// no dependencies

package tli_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PTS_W       = 8;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int CNT_W       = $clog2(PROD_W);

  localparam logic [PTS_W-1:0] POINTS_RESET = PTS_W'(101);
  localparam logic [PTS_W-1:0] POINTS_MIN   = PTS_W'(2);
  localparam logic [PTS_W-1:0] POINTS_MAX   = PTS_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_R2Z  = 2'd1,
    OP_Z2R  = 2'd2,
    OP_NONE = 2'd3
  } tli_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ZLAST_RD,
    ST_ZFIRST_RD,
    ST_ZCHK,
    ST_GRID,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_LERP,
    ST_DIV
  } tli_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } tli_md_phase_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [VALUE_W-1:0] radius;
    logic [VALUE_W-1:0] redshift;
  } tli_wr_t;

endpackage

/* src/tli_table.sv */
// radius and redshift point memories, one write and one registered read port
// depends on tli_pkg

module tli_table (
  input  logic                          clk,
  input  tli_pkg::tli_wr_t              wr,
  input  logic [tli_pkg::IDX_W-1:0]     rd_addr,
  output logic [tli_pkg::VALUE_W-1:0]   rd_rad,
  output logic [tli_pkg::VALUE_W-1:0]   rd_z
);
  import tli_pkg::*;

  logic [VALUE_W-1:0] radius_store   [0:TABLE_DEPTH-1];
  logic [VALUE_W-1:0] redshift_store [0:TABLE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      radius_store[wr.addr]   <= wr.radius;
      redshift_store[wr.addr] <= wr.redshift;
    end
  end

  always_ff @(posedge clk) begin
    rd_rad <= radius_store[rd_addr];
    rd_z   <= redshift_store[rd_addr];
  end

endmodule

/* src/tli_muldiv.sv */
// bit-serial floor(a * b / d): shift-add multiply, then restoring divide
// depends on tli_pkg

module tli_muldiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tli_pkg::VALUE_W-1:0]  a,
  input  logic [tli_pkg::VALUE_W-1:0]  b,
  input  logic [tli_pkg::VALUE_W-1:0]  d,
  output logic                         done,
  output logic [tli_pkg::PROD_W-1:0]   quo
);
  import tli_pkg::*;

  tli_md_phase_t      phase, phase_next;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] mcand;
  logic [VALUE_W-1:0] dvs;
  logic [VALUE_W-1:0] rem;
  logic [PROD_W-1:0]  prod;
  logic               mul_en, div_en, mul_last, div_last;
  logic [VALUE_W:0]   psum, shifted, diff;
  logic               ge;

  assign mul_last = (cnt == CNT_W'(VALUE_W - 1));
  assign div_last = (cnt == CNT_W'(PROD_W - 1));

  always_comb begin
    phase_next = phase;
    case (phase)
      MD_IDLE: begin
        if (start) phase_next = MD_MUL;
      end
      MD_MUL: begin
        if (mul_last) phase_next = MD_DIV;
      end
      MD_DIV: begin
        if (div_last) phase_next = MD_IDLE;
      end
      default: phase_next = MD_IDLE;
    endcase
  end

  always_comb begin
    mul_en = 1'b0;
    div_en = 1'b0;
    case (phase)
      MD_MUL:  mul_en = 1'b1;
      MD_DIV:  div_en = 1'b1;
      default: ;
    endcase
  end

  assign psum    = {1'b0, prod[PROD_W-1:VALUE_W]} + (prod[0] ? {1'b0, mcand} : '0);
  assign shifted = {rem, prod[PROD_W-1]};
  assign ge      = (shifted >= {1'b0, dvs});
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MD_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      done  <= div_en && div_last;
      if (start && phase == MD_IDLE) begin
        cnt <= '0;
      end else if (mul_en) begin
        cnt <= mul_last ? '0 : cnt + 1'b1;
      end else if (div_en) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && phase == MD_IDLE) begin
      mcand <= a;
      dvs   <= d;
      prod  <= {{VALUE_W{1'b0}}, b};
      rem   <= '0;
    end else if (mul_en) begin
      prod <= {psum, prod[VALUE_W-1:1]};
      rem  <= '0;
    end else if (div_en) begin
      rem  <= ge ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
      prod <= {prod[PROD_W-2:0], ge};
    end
  end

  assign quo = prod;

endmodule

/* src/table_linear_interpolator.sv */
// Table linear interpolator: a load (operation 0) writes one point and gives no result
// word. A radius query reads one table entry per cycle through the single memory read
// port until it finds the segment, then runs one bit-serial multiply-divide (32 multiply
// steps, 64 divide steps); a radius beyond the table ends the scan with out_of_range set.
// A redshift query runs two serial multiply-divides, one for the grid index and one for
// the interpolation; the grid one is skipped when the redshift span is flat, and neither
// runs when the query is rejected. A flat segment skips the interpolating multiply-divide.
// busy is high for a query from the cycle after start until the result word; the result
// is on result_value and out_of_range for exactly the one cycle that done is high and
// must be taken then. points_in_use may be written only while busy is low.
// depends on tli_pkg, tli_table, tli_muldiv

module table_linear_interpolator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation,
  input  logic [tli_pkg::IDX_W-1:0]    entry_index,
  input  logic [tli_pkg::VALUE_W-1:0]  entry_radius,
  input  logic [tli_pkg::VALUE_W-1:0]  entry_redshift,
  input  logic [tli_pkg::VALUE_W-1:0]  query_value,
  input  logic                         cfg_we,
  input  logic [tli_pkg::PTS_W-1:0]    cfg_wdata,
  output logic [tli_pkg::VALUE_W-1:0]  result_value,
  output logic                         out_of_range,
  output logic                         done
);
  import tli_pkg::*;

  tli_state_t         state, state_next;
  tli_op_t            op_r;
  logic [VALUE_W-1:0] q_r;
  logic [PTS_W-1:0]   points;
  logic [PTS_W-1:0]   n_act;
  logic [PTS_W-1:0]   scan_addr;
  logic [PTS_W-1:0]   data_idx;
  logic               chk;
  logic [IDX_W-1:0]   seg;
  logic [VALUE_W-1:0] zlast;
  logic [VALUE_W-1:0] lo_rad, lo_z, hi_rad, hi_z;
  logic [VALUE_W-1:0] y0_r;
  logic               neg_r;

  tli_wr_t            wr;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_rad, rd_z;

  logic               md_start, md_done;
  logic [VALUE_W-1:0] md_a, md_b, md_d;
  logic [PROD_W-1:0]  md_quo;

  logic               accept;
  logic               scan_hit, scan_miss, z_oor, z_span;
  logic [VALUE_W-1:0] x0, x1, y0, y1;
  logic               negy, negx, negd, flat;
  logic [VALUE_W-1:0] my, mx, md;
  logic               q_hi_nz;
  logic [VALUE_W-1:0] qlo;
  logic [VALUE_W:0]   up_sum;
  logic [VALUE_W-1:0] fin_val;
  logic               g_big;
  logic [IDX_W-1:0]   seg_grid;

  logic               res_fire, res_oor;
  logic [VALUE_W-1:0] res_val;

  tli_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_rad  (rd_rad),
    .rd_z    (rd_z)
  );

  tli_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .done  (md_done),
    .quo   (md_quo)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  always_comb begin
    if (points < POINTS_MIN) begin
      n_act = POINTS_MIN;
    end else if (points > POINTS_MAX) begin
      n_act = POINTS_MAX;
    end else begin
      n_act = points;
    end
  end

  always_comb begin
    wr.en       = accept && (operation == OP_LOAD);
    wr.addr     = entry_index;
    wr.radius   = entry_radius;
    wr.redshift = entry_redshift;
  end

  // segment scan, one entry per cycle behind the read port
  assign scan_hit  = chk && (rd_rad > q_r);
  assign scan_miss = chk && !scan_hit && (data_idx == n_act - PTS_W'(1));

  assign z_oor  = (q_r > zlast);
  assign z_span = (zlast > rd_z);

  always_comb begin
    if (op_r == OP_R2Z) begin
      x0 = lo_rad;
      x1 = hi_rad;
      y0 = lo_z;
      y1 = hi_z;
    end else begin
      x0 = lo_z;
      x1 = hi_z;
      y0 = lo_rad;
      y1 = hi_rad;
    end
  end

  assign negy = (y1 < y0);
  assign negx = (q_r < x0);
  assign negd = (x1 < x0);
  assign my   = negy ? (y0 - y1) : (y1 - y0);
  assign mx   = negx ? (x0 - q_r) : (q_r - x0);
  assign md   = negd ? (x0 - x1) : (x1 - x0);
  assign flat = (md == '0);

  // saturate y0 +/- quotient
  assign q_hi_nz = |md_quo[PROD_W-1:VALUE_W];
  assign qlo     = md_quo[VALUE_W-1:0];
  assign up_sum  = {1'b0, y0_r} + {1'b0, qlo};

  always_comb begin
    if (neg_r) begin
      fin_val = (q_hi_nz || qlo >= y0_r) ? '0 : y0_r - qlo;
    end else begin
      fin_val = (q_hi_nz || up_sum[VALUE_W]) ? '1 : up_sum[VALUE_W-1:0];
    end
  end

  assign g_big    = (|md_quo[PROD_W-1:PTS_W]) || (md_quo[PTS_W-1:0] > n_act - PTS_W'(2));
  assign seg_grid = g_big ? IDX_W'(n_act - PTS_W'(2)) : md_quo[IDX_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_R2Z) begin
            state_next = ST_SCAN;
          end else if (operation == OP_Z2R) begin
            state_next = ST_ZLAST_RD;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_next = ST_F0;
        end else if (scan_miss) begin
          state_next = ST_IDLE;
        end
      end
      ST_ZLAST_RD:  state_next = ST_ZFIRST_RD;
      ST_ZFIRST_RD: state_next = ST_ZCHK;
      ST_ZCHK: begin
        if (z_oor) begin
          state_next = ST_IDLE;
        end else if (z_span) begin
          state_next = ST_GRID;
        end else begin
          state_next = ST_F0;
        end
      end
      ST_GRID: begin
        if (md_done) state_next = ST_F0;
      end
      ST_F0: state_next = ST_F1;
      ST_F1: begin
        state_next = (op_r == OP_R2Z) ? ST_LERP : ST_F2;
      end
      ST_F2: state_next = ST_LERP;
      ST_LERP: begin
        state_next = flat ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (md_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr  = seg;
    md_start = 1'b0;
    md_a     = mx;
    md_b     = my;
    md_d     = md;
    res_fire = 1'b0;
    res_oor  = 1'b0;
    res_val  = '0;
    case (state)
      ST_SCAN: begin
        rd_addr = scan_addr[IDX_W-1:0];
        if (scan_miss) begin
          res_fire = 1'b1;
          res_oor  = 1'b1;
        end
      end
      ST_ZLAST_RD: begin
        rd_addr = IDX_W'(n_act - PTS_W'(1));
      end
      ST_ZFIRST_RD: begin
        rd_addr = '0;
      end
      ST_ZCHK: begin
        md_a = q_r;
        md_b = VALUE_W'(n_act - PTS_W'(1));
        md_d = zlast - rd_z;
        if (z_oor) begin
          res_fire = 1'b1;
          res_oor  = 1'b1;
        end else if (z_span) begin
          md_start = 1'b1;
        end
      end
      ST_F0: begin
        rd_addr = seg;
      end
      ST_F1: begin
        rd_addr = seg + 1'b1;
      end
      ST_LERP: begin
        if (flat) begin
          res_fire = 1'b1;
          res_val  = y0;
        end else begin
          md_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (md_done) begin
          res_fire = 1'b1;
          res_val  = fin_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      chk    <= 1'b0;
      points <= POINTS_RESET;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      chk   <= (state == ST_SCAN);
      done  <= res_fire;
      if (cfg_we) points <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    data_idx <= scan_addr;
    if (res_fire) begin
      result_value <= res_val;
      out_of_range <= res_oor;
    end
    if (accept) begin
      op_r      <= tli_op_t'(operation);
      q_r       <= query_value;
      scan_addr <= PTS_W'(1);
    end
    case (state)
      ST_SCAN: begin
        scan_addr <= scan_addr + 1'b1;
        if (scan_hit) begin
          seg    <= IDX_W'(data_idx - PTS_W'(1));
          hi_rad <= rd_rad;
          hi_z   <= rd_z;
        end
      end
      ST_ZFIRST_RD: zlast <= rd_z;
      ST_ZCHK: begin
        if (!z_span) seg <= '0;
      end
      ST_GRID: begin
        if (md_done) seg <= seg_grid;
      end
      ST_F1: begin
        lo_rad <= rd_rad;
        lo_z   <= rd_z;
      end
      ST_F2: begin
        hi_rad <= rd_rad;
        hi_z   <= rd_z;
      end
      ST_LERP: begin
        y0_r  <= y0;
        neg_r <= negy ^ negx ^ negd;
      end
      default: ;
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_LOAD) |=> !done)
    else $error("load produced a result word");

  a_md_done_state: assert property (@(posedge clk) disable iff (rst)
    md_done |-> (state == ST_GRID || state == ST_DIV))
    else $error("divider finished outside a waiting state");

  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_F0) |-> ({1'b0, seg} <= n_act - PTS_W'(2)))
    else $error("segment index beyond table");

endmodule

/* verif/table_linear_interpolator_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for table_linear_interpolator: table loads, radius and redshift
// queries and points_in_use writes, each result word checked against an in-bench predictor
// depends on tli_pkg and table_linear_interpolator

module table_linear_interpolator_tb;
  import tli_pkg::*;

  localparam int SETTLE = 8;
  localparam int LIMIT = 3000000;
  localparam int RAND_WORDS = 1600;
  localparam logic [VALUE_W-1:0] VMAX = '1;

  typedef enum logic [1:0] {CMD_WORD, CMD_HOLD, CMD_CFG} cmd_kind_t;

  typedef struct {
    cmd_kind_t          kind;
    tli_op_t            op;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] rad;
    logic [VALUE_W-1:0] zs;
    logic [VALUE_W-1:0] qv;
    logic [PTS_W-1:0]   pts;
    int                 gap;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               oor;
  } answer_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation = '0;
  logic [IDX_W-1:0]   entry_index = '0;
  logic [VALUE_W-1:0] entry_radius = '0;
  logic [VALUE_W-1:0] entry_redshift = '0;
  logic [VALUE_W-1:0] query_value = '0;
  logic               cfg_we = 1'b0;
  logic [PTS_W-1:0]   cfg_wdata = '0;
  logic [VALUE_W-1:0] result_value;
  logic               out_of_range;
  logic               done;

  table_linear_interpolator i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .entry_index    (entry_index),
    .entry_radius   (entry_radius),
    .entry_redshift (entry_redshift),
    .query_value    (query_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .result_value   (result_value),
    .out_of_range   (out_of_range),
    .done           (done)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  cmd_t               cmd_q[$];
  answer_t            answer_q[$];
  cmd_t               cur;
  logic [VALUE_W-1:0] tbl_r [TABLE_DEPTH];
  logic [VALUE_W-1:0] tbl_z [TABLE_DEPTH];
  logic [PTS_W-1:0]   pts_cfg = POINTS_RESET;
  logic [VALUE_W-1:0] gen_r [TABLE_DEPTH];
  logic [VALUE_W-1:0] gen_z [TABLE_DEPTH];
  int                 gen_n;
  bit                 gappy_now = 1'b0;
  int                 rand_words = 0;
  int                 gap_seen = 0;
  int                 quiet = 0;
  int                 errs = 0;
  int                 n_load = 0, n_r2z = 0, n_z2r = 0, n_oor = 0, n_cfg = 0;
  int unsigned        cycles = 0;

  function automatic int eff_points(logic [PTS_W-1:0] v);
    if (v < POINTS_MIN) return int'(POINTS_MIN);
    if (v > POINTS_MAX) return int'(POINTS_MAX);
    return int'(v);
  endfunction

  // y0 + (y1-y0)*(x-x0)/(x1-x0), truncated toward zero, clipped to the value range
  function automatic logic [VALUE_W-1:0] interp_sat(logic [VALUE_W-1:0] y0, y1, x, x0, x1);
    logic [63:0] dy, dx, dd, q;
    dy = (y1 < y0) ? 64'(y0 - y1) : 64'(y1 - y0);
    dx = (x < x0) ? 64'(x0 - x) : 64'(x - x0);
    dd = (x1 < x0) ? 64'(x0 - x1) : 64'(x1 - x0);
    if (dd == 64'd0) return y0;
    q = (dy * dx) / dd;
    if ((y1 < y0) ^ (x < x0) ^ (x1 < x0))
      return (q >= 64'(y0)) ? '0 : y0 - q[VALUE_W-1:0];
    return (q > 64'(VMAX - y0)) ? VMAX : y0 + q[VALUE_W-1:0];
  endfunction

  function automatic void predict_answer(input cmd_t w, output bit has, output answer_t a);
    int n, i;
    logic [63:0] g;
    logic [VALUE_W-1:0] zl, zf;
    has = 1'b0;
    a = '0;
    n = eff_points(pts_cfg);
    case (w.op)
      OP_LOAD: begin
        tbl_r[w.idx] = w.rad;
        tbl_z[w.idx] = w.zs;
        n_load++;
      end
      OP_R2Z: begin
        has = 1'b1;
        n_r2z++;
        a.oor = 1'b1;
        for (i = 0; i + 1 < n && a.oor; i++) begin
          if (tbl_r[i+1] > w.qv) begin
            a.value = interp_sat(tbl_z[i], tbl_z[i+1], w.qv, tbl_r[i], tbl_r[i+1]);
            a.oor = 1'b0;
          end
        end
      end
      OP_Z2R: begin
        has = 1'b1;
        n_z2r++;
        zl = tbl_z[n-1];
        zf = tbl_z[0];
        if (w.qv > zl) begin
          a.oor = 1'b1;
        end else begin
          g = '0;
          if (zl > zf) g = (64'(w.qv) * 64'(n - 1)) / 64'(zl - zf);
          if (g > 64'(n - 2)) g = 64'(n - 2);
          i = int'(g);
          a.value = interp_sat(tbl_r[i], tbl_r[i+1], w.qv, tbl_z[i], tbl_z[i+1]);
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    bit pres, we, took, has;
    answer_t a;
    cmd_t c;
    if (!rst) begin
      pres = start;
      we = 1'b0;
      took = start && !busy;
      if (took) begin
        predict_answer(cur, has, a);
        if (has) answer_q.push_back(a);
        pres = 1'b0;
        quiet = 0;
      end
      if (!pres && cmd_q.size() > 0) begin
        if (cmd_q[0].kind == CMD_WORD) begin
          if (gap_seen < cmd_q[0].gap) begin
            if (!busy) gap_seen++;
          end else begin
            cur = cmd_q.pop_front();
            operation <= cur.op;
            entry_index <= cur.idx;
            entry_radius <= cur.rad;
            entry_redshift <= cur.zs;
            query_value <= cur.qv;
            pres = 1'b1;
            gap_seen = 0;
          end
        end else begin
          if (answer_q.size() == 0 && !busy && !took) quiet++;
          else quiet = 0;
          if (quiet >= SETTLE) begin
            c = cmd_q.pop_front();
            if (c.kind == CMD_CFG) begin
              we = 1'b1;
              cfg_wdata <= c.pts;
              pts_cfg = c.pts;
              n_cfg++;
            end
            quiet = 0;
          end
        end
      end
      start <= pres;
      cfg_we <= we;
    end
  end

  task automatic flag_error(string what, logic [VALUE_W-1:0] exp_v, logic [VALUE_W-1:0] act_v);
    errs++;
    if (errs <= 10)
      $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, act_v, $time);
  endtask

  // monitor
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (out_of_range) n_oor++;
      if (answer_q.size() == 0) begin
        flag_error("word with none pending", '0, result_value);
      end else begin
        want = answer_q.pop_front();
        if (result_value !== want.value) flag_error("result_value", want.value, result_value);
        if (out_of_range !== want.oor)
          flag_error("out_of_range", VALUE_W'(want.oor), VALUE_W'(out_of_range));
      end
    end
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_word(tli_op_t op, logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] rad,
                           logic [VALUE_W-1:0] zs, logic [VALUE_W-1:0] qv);
    cmd_t c;
    c.kind = CMD_WORD;
    c.op = op;
    c.idx = idx;
    c.rad = rad;
    c.zs = zs;
    c.qv = qv;
    c.pts = '0;
    c.gap = (gappy_now && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (op == OP_LOAD) begin
      gen_r[idx] = rad;
      gen_z[idx] = zs;
    end
    if (op != OP_NONE) rand_words++;
    cmd_q.push_back(c);
  endtask

  task automatic push_ctl(cmd_kind_t k, logic [PTS_W-1:0] v);
    cmd_t c;
    c = '{kind: k, op: OP_NONE, idx: '0, rad: '0, zs: '0, qv: '0, pts: v, gap: 0};
    if (k == CMD_CFG) gen_n = eff_points(v);
    cmd_q.push_back(c);
  endtask

  // styles: 0 rising, 1 random, 2 falling, 3 rising with flat spots
  task automatic load_table(int style);
    logic [63:0] r, z;
    int unsigned sr, sz;
    int i, j;
    r = 64'($urandom_range(0, 1 << 20));
    z = 64'($urandom_range(0, 1 << 20));
    sr = 1 << $urandom_range(0, 24);
    sz = 1 << $urandom_range(0, 24);
    for (i = 0; i < gen_n; i++) begin
      j = (style == 2) ? gen_n - 1 - i : i;
      if (style == 1) push_word(OP_LOAD, IDX_W'(j), $urandom, $urandom, $urandom);
      else push_word(OP_LOAD, IDX_W'(j), r[VALUE_W-1:0], z[VALUE_W-1:0], $urandom);
      if (!(style == 3 && $urandom_range(0, 3) == 0)) r += 64'($urandom_range(0, sr));
      if (!(style == 3 && $urandom_range(0, 3) == 0)) z += 64'($urandom_range(1, sz));
    end
    if (style == 3 && $urandom_range(0, 1) == 0)
      push_word(OP_LOAD, IDX_W'(gen_n - 1), gen_r[gen_n-1],
                $urandom_range(0, 1) ? gen_z[0] : '0, '0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_query(bit on_z);
    logic [VALUE_W-1:0] lo, hi, p;
    int k;
    k = $urandom_range(0, gen_n - 1);
    lo = on_z ? gen_z[0] : gen_r[0];
    hi = on_z ? gen_z[gen_n-1] : gen_r[gen_n-1];
    p = on_z ? gen_z[k] : gen_r[k];
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? '0 : VMAX;
      2, 3: return p;
      4: return p + VALUE_W'($urandom_range(0, 4)) - VALUE_W'(2);
      default: begin
        if (hi > lo)
          return lo + VALUE_W'((64'($urandom) * (64'(hi) - 64'(lo) + 64'd1)) >> 32);
        return p;
      end
    endcase
  endfunction

  initial begin
    logic [PTS_W-1:0] pts;
    int k, items, style;

    // every entry written first so no query reads an unwritten one
    gen_n = TABLE_DEPTH;
    load_table(0);
    gen_n = eff_points(POINTS_RESET);

    push_word(OP_R2Z, '0, '0, '0, '0);
    push_word(OP_R2Z, '0, '0, '0, VMAX);
    push_word(OP_R2Z, '0, '0, '0, gen_r[50]);
    push_word(OP_R2Z, '0, '0, '0, gen_r[gen_n-1]);
    push_word(OP_Z2R, '0, '0, '0, '0);
    push_word(OP_Z2R, '0, '0, '0, VMAX);
    push_word(OP_Z2R, '0, '0, '0, gen_z[gen_n-1]);
    push_word(OP_Z2R, '0, '0, '0, gen_z[gen_n-1] + VALUE_W'(1));
    push_word(OP_NONE, '1, VMAX, VMAX, VMAX);
    push_word(OP_LOAD, IDX_W'(TABLE_DEPTH - 1), VMAX, VMAX, '0);
    push_ctl(CMD_CFG, '1);
    push_word(OP_R2Z, '0, '0, '0, VMAX - VALUE_W'(1));
    push_word(OP_Z2R, '0, '0, '0, VMAX);
    push_ctl(CMD_CFG, '0);
    // flat radius segment
    push_word(OP_LOAD, IDX_W'(0), VALUE_W'(100), VALUE_W'(5), '0);
    push_word(OP_LOAD, IDX_W'(1), VALUE_W'(100), VALUE_W'(9), '0);
    push_word(OP_R2Z, '0, '0, '0, VALUE_W'(50));
    // flat redshift span
    push_word(OP_LOAD, IDX_W'(0), VALUE_W'(1), VALUE_W'(7), '0);
    push_word(OP_LOAD, IDX_W'(1), VALUE_W'(2), VALUE_W'(7), '0);
    push_word(OP_Z2R, '0, '0, '0, VALUE_W'(7));
    // clip high, then clip at zero
    push_word(OP_LOAD, IDX_W'(0), VALUE_W'(1000), VALUE_W'(32'hF000_0000), '0);
    push_word(OP_LOAD, IDX_W'(1), VALUE_W'(2000), '0, '0);
    push_word(OP_R2Z, '0, '0, '0, '0);
    push_word(OP_LOAD, IDX_W'(0), VALUE_W'(1000), VALUE_W'(10), '0);
    push_word(OP_LOAD, IDX_W'(1), VALUE_W'(2000), VALUE_W'(20), '0);
    push_word(OP_R2Z, '0, '0, '0, '0);
    push_ctl(CMD_HOLD, '0);
    push_ctl(CMD_CFG, PTS_W'(1));
    push_ctl(CMD_CFG, PTS_W'(129));

    rand_words = 0;
    while (rand_words < RAND_WORDS) begin
      gappy_now = (rand_words < RAND_WORDS * 7 / 8) && $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
        0: pts = $urandom_range(0, 1) ? PTS_W'($urandom_range(0, 2))
                                       : PTS_W'($urandom_range(128, 255));
        1, 2: pts = PTS_W'($urandom_range(2, 128));
        default: pts = PTS_W'($urandom_range(2, 24));
      endcase
      push_ctl(CMD_CFG, pts);
      case ($urandom_range(0, 9))
        0: style = 1;
        1, 2: style = 2;
        3: style = 3;
        default: style = 0;
      endcase
      load_table(style);
      items = $urandom_range(15, 50);
      for (k = 0; k < items; k++) begin
        case ($urandom_range(0, 19))
          0, 1: push_word(OP_LOAD, IDX_W'($urandom), $urandom, $urandom, $urandom);
          2: push_word(OP_NONE, IDX_W'($urandom), $urandom, $urandom, $urandom);
          3: push_ctl(CMD_HOLD, '0);
          4, 5, 6, 7, 8, 9, 10, 11:
            push_word(OP_R2Z, IDX_W'($urandom), $urandom, $urandom, pick_query(1'b0));
          default:
            push_word(OP_Z2R, IDX_W'($urandom), $urandom, $urandom, pick_query(1'b1));
        endcase
      end
    end

    while (cmd_q.size() != 0 || start) @(negedge clk);
    while (answer_q.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE * 4) @(negedge clk);

    $display("covered %0d radius and %0d redshift queries (%0d beyond the table)",
             n_r2z, n_z2r, n_oor);
    $display("plus %0d table loads and %0d points_in_use writes, %0d mismatches",
             n_load, n_cfg, errs);
    if (errs == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
src/tli_pkg.sv
src/tli_table.sv
src/tli_muldiv.sv
src/table_linear_interpolator.sv
verif/table_linear_interpolator_tb.sv
